// ===== hw/rtl/hks_pkg.sv =====
// Package: constants, types and character functions of the key scramble field generator.
`default_nettype none
package hks_pkg;

	localparam int KEY_W      = 32;
	localparam int CHAR_W     = 7;
	localparam int IDX_W      = 5;
	localparam int RAW_BYTES  = 20;
	localparam int RAW_W      = 8 * RAW_BYTES;
	localparam int SH_W       = RAW_W + 2;
	localparam int FIELD_LEN  = 28;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIELD_LEN - 1);
	localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3d;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// version text, zero padded to 16 bytes
	localparam logic [127:0] VER_TEXT = {"EN V2.40-0335", 24'h000000};
	// fixed scramble key, 12 bytes
	localparam logic [95:0] FKEY = 96'h48756157656933434F4D3158;

	typedef logic [RAW_W-1:0] raw_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] hex_char(logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'h0, n};
		end else begin
			r = 8'h57 + {4'h0, n};
		end
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] b64_char(logic [5:0] v);
		logic [CHAR_W-1:0] r;
		priority if (v < 6'd26) begin
			r = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			r = 7'h47 + {1'b0, v};
		end else if (v < 6'd62) begin
			r = {1'b0, v} - 7'd4;
		end else if (v == 6'd62) begin
			r = 7'h2b;
		end else begin
			r = 7'h2f;
		end
		return r;
	endfunction

	function automatic raw_t raw_field(logic [KEY_W-1:0] key);
		logic [7:0] hex [8];
		logic [7:0] b;
		raw_t raw;
		for (int k = 0; k < 8; k++) begin
			hex[k] = hex_char(key[31-4*k -: 4]);
		end
		for (int k = 0; k < RAW_BYTES; k++) begin
			if (k < 16) begin
				b = VER_TEXT[127-8*k -: 8] ^ hex[k%8] ^ hex[7-(k%8)];
			end else begin
				b = key[31-8*(k-16) -: 8];
			end
			b = b ^ FKEY[95-8*(k%12) -: 8] ^ FKEY[95-8*((19-k)%12) -: 8];
			raw[RAW_W-1-8*k -: 8] = b;
		end
		return raw;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hks_if.sv =====
// Channel interfaces: key input and field character output.
`default_nettype none
interface hks_key_if;
	logic                        valid;
	logic                        ready;
	logic [hks_pkg::KEY_W-1:0]   key;
	modport source (output valid, output key, input ready);
	modport sink   (input valid, input key, output ready);
endinterface

interface hks_char_if;
	logic                        valid;
	logic                        ready;
	logic [hks_pkg::CHAR_W-1:0]  out_char;
	logic [hks_pkg::IDX_W-1:0]   char_index;
	logic                        last;
	modport source (output valid, output out_char, output char_index, output last,
		input ready);
	modport sink   (input valid, input out_char, input char_index, input last,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hks_front.sv =====
// Front end: accepts keys and builds the scrambled 20-byte field for the queue.
`default_nettype none
module hks_front (
	hks_key_if.sink          keys,
	input  hks_pkg::q_stat_t qstat,
	output logic             push,
	output hks_pkg::raw_t    push_data
);

	assign keys.ready = !qstat.full;
	assign push       = keys.valid && !qstat.full;
	assign push_data  = hks_pkg::raw_field(keys.key);

endmodule
`default_nettype wire

// ===== hw/rtl/hks_queue.sv =====
// Two-entry queue of scrambled fields between front and back end.
`default_nettype none
module hks_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hks_pkg::raw_t    push_data,
	input  logic             pop,
	output hks_pkg::raw_t    pop_data,
	output hks_pkg::q_stat_t qstat
);

	hks_pkg::raw_t                   mem_q [hks_pkg::QDEPTH];
	logic [hks_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [hks_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [hks_pkg::QCNT_W-1:0]      cnt_q;

	function automatic logic [hks_pkg::QPTR_W-1:0] ptr_next(logic [hks_pkg::QPTR_W-1:0] p);
		logic [hks_pkg::QPTR_W-1:0] r;
		if (p == hks_pkg::QPTR_W'(hks_pkg::QDEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + hks_pkg::QPTR_W'(1);
		end
		return r;
	endfunction

	assign qstat.full  = (cnt_q == hks_pkg::QCNT_W'(hks_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + hks_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - hks_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/hks_back.sv =====
// Back end: serializes one field into 28 base64 characters through an output register.
`default_nettype none
module hks_back (
	input  logic             clk,
	input  logic             arst_n,
	input  hks_pkg::q_stat_t qstat,
	input  hks_pkg::raw_t    pop_data,
	output logic             pop,
	hks_char_if.source       chars
);

	logic [hks_pkg::SH_W-1:0]   sh_q;
	logic [hks_pkg::IDX_W-1:0]  cnt_q;
	logic                       busy_q;
	logic                       ov_q;
	logic [hks_pkg::CHAR_W-1:0] char_q;
	logic [hks_pkg::IDX_W-1:0]  idx_q;
	logic                       last_q;

	logic                       adv;
	logic                       at_end;
	logic                       load;
	logic [hks_pkg::CHAR_W-1:0] char_d;

	assign adv    = busy_q && (!ov_q || chars.ready);
	assign at_end = (cnt_q == hks_pkg::LAST_IDX);
	assign load   = !qstat.empty && (!busy_q || (adv && at_end));
	assign pop    = load;
	assign char_d = at_end ? hks_pkg::PAD_CHAR
		: hks_pkg::b64_char(sh_q[hks_pkg::SH_W-1 -: 6]);

	assign chars.valid      = ov_q;
	assign chars.out_char   = char_q;
	assign chars.char_index = idx_q;
	assign chars.last       = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= {pop_data, 2'b00};
		end else if (adv) begin
			sh_q <= {sh_q[hks_pkg::SH_W-7:0], 6'b000000};
		end
		if (adv) begin
			char_q <= char_d;
			idx_q  <= cnt_q;
			last_q <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (adv) begin
				cnt_q <= cnt_q + hks_pkg::IDX_W'(1);
				if (at_end) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (chars.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/hex_key_scramble_base64_top.sv =====
// Top level of the key scramble field generator.
// Each accepted 32-bit key yields one 28-character base64 field, indices 0 to 27, with
// last set on the closing '=' character. Characters leave one per cycle while ready is
// held, from a registered output. Keys can be accepted back to back while a two-entry
// field queue has room, and the serializer picks up the next field in the same cycle
// as the previous last character is registered. At an idle block, a key's field goes
// through the field queue and the shift register before its first character is output.
`default_nettype none
module hex_key_scramble_base64_top (
	input  logic       clk,
	input  logic       arst_n,
	hks_key_if.sink    keys,
	hks_char_if.source chars
);

	hks_pkg::q_stat_t qstat;
	logic             push;
	hks_pkg::raw_t    push_data;
	logic             pop;
	hks_pkg::raw_t    pop_data;

	hks_front u_front (
		.keys      (keys),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	hks_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	hks_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_data (pop_data),
		.pop      (pop),
		.chars    (chars)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/hks_check.sv =====
// Port-level checker for the field generator, bound to the top level.
`default_nettype none
module hks_check (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cv,
	input logic                       cr,
	input logic [hks_pkg::CHAR_W-1:0] out_char,
	input logic [hks_pkg::IDX_W-1:0]  char_index,
	input logic                       last
);

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cv |-> (last == (char_index == hks_pkg::LAST_IDX)))
		else $error("last flag does not match index");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(cv && last) |-> (out_char == hks_pkg::PAD_CHAR))
		else $error("final character is not pad");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(cv && cr && !last) |=>
		(cv && (char_index == hks_pkg::IDX_W'($past(char_index) + 1'b1))))
		else $error("field characters not contiguous");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cv && !cr) |=> (cv && $stable(out_char) && $stable(char_index) && $stable(last)))
		else $error("stalled transaction changed");

endmodule

bind hex_key_scramble_base64_top hks_check u_hks_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.cv         (chars.valid),
	.cr         (chars.ready),
	.out_char   (chars.out_char),
	.char_index (chars.char_index),
	.last       (chars.last)
);
`default_nettype wire
